>>> hw/rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character constants and helper functions for the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  typedef enum logic [5:0] {
    PH_NORMAL = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_HEX1   = 6'b000100,
    PH_HEX2   = 6'b001000,
    PH_OCT1   = 6'b010000,
    PH_OCT2   = 6'b100000
  } phase_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;  // 'x'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CH_LA     = 8'h61;  // 'a'
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  localparam logic [7:0] CC_BEL = 8'd7;
  localparam logic [7:0] CC_BS  = 8'd8;
  localparam logic [7:0] CC_FF  = 8'd12;
  localparam logic [7:0] CC_LF  = 8'd10;
  localparam logic [7:0] CC_CR  = 8'd13;
  localparam logic [7:0] CC_HT  = 8'd9;
  localparam logic [7:0] CC_VT  = 8'd11;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  partial;
  } esd_state_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  value;
    logic        last;
    logic        truncated;
  } esd_result_t;

  localparam esd_state_t STATE_RESET = '{phase: PH_NORMAL, partial: 8'h00};

  // Out-of-range digits wrap through the same subtraction.
  function automatic logic [7:0] hex_val(input logic [7:0] d);
    logic [7:0] v;
    if (d < CH_UA) begin
      v = d - CH_ZERO;
    end else if (d >= CH_LA) begin
      v = d - CH_LA + HEX_TEN;
    end else begin
      v = d - CH_UA + HEX_TEN;
    end
    return v;
  endfunction

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_LA:   v = CC_BEL;
      CH_LB:   v = CC_BS;
      CH_LF:   v = CC_FF;
      CH_LN:   v = CC_LF;
      CH_LR:   v = CC_CR;
      CH_LT:   v = CC_HT;
      CH_LV:   v = CC_VT;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/esd_in_if.sv
// ----------------------------------------------------------------------------
// esd_in_if
// Valid/ready channel carrying raw escaped bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/esd_out_if.sv
// ----------------------------------------------------------------------------
// esd_out_if
// Valid/ready channel carrying decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_truncated;

  modport source (output valid, output out_byte, output out_last,
                  output out_truncated, input ready);
  modport sink   (input valid, input out_byte, input out_last,
                  input out_truncated, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/esd_decode.sv
// ----------------------------------------------------------------------------
// esd_decode
// Next-state and result logic for one raw byte.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_decode
  import esd_pkg::*;
(
  input  esd_state_t  state,
  input  logic [7:0]  byte_in,
  input  logic        last_in,
  output esd_state_t  state_next,
  output esd_result_t result
);

  esd_state_t  st;
  logic        emit;
  logic [7:0]  val;
  logic [7:0]  hex_d;
  logic [7:0]  oct_d;

  assign hex_d = hex_val(byte_in);
  assign oct_d = byte_in - CH_ZERO;

  always_comb begin
    st   = state;
    emit = 1'b0;
    val  = byte_in;
    unique case (state.phase)
      PH_NORMAL: begin
        if (byte_in == CH_BSLASH) begin
          st.phase = PH_ESC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_ESC: begin
        if (byte_in == CH_X) begin
          st.partial = 8'h00;
          st.phase   = PH_HEX1;
        end else if (byte_in == CH_ZERO) begin
          st.partial = 8'h00;
          st.phase   = PH_OCT1;
        end else begin
          emit     = 1'b1;
          val      = simple_escape(byte_in);
          st.phase = PH_NORMAL;
        end
      end
      PH_HEX1: begin
        st.partial = {hex_d[3:0], 4'h0};
        st.phase   = PH_HEX2;
      end
      PH_HEX2: begin
        emit     = 1'b1;
        val      = state.partial | hex_d;
        st.phase = PH_NORMAL;
      end
      PH_OCT1: begin
        st.partial = {oct_d[4:0], 3'b000};
        st.phase   = PH_OCT2;
      end
      PH_OCT2: begin
        emit     = 1'b1;
        val      = state.partial | oct_d;
        st.phase = PH_NORMAL;
      end
      default: begin
        emit     = 1'b1;
        st.phase = PH_NORMAL;
      end
    endcase
  end

  always_comb begin
    result.emit      = emit || last_in;
    result.last      = last_in;
    result.truncated = last_in && !emit;
    if (emit) begin
      result.value = val;
    end else begin
      // string ended with an escape still open
      result.value = (st.phase == PH_ESC) ? CH_BSLASH : st.partial;
    end
    state_next = last_in ? STATE_RESET : st;
  end

endmodule

`default_nettype wire

>>> hw/rtl/escape_sequence_decoder.sv
// Each byte passes through the input register and then the result register.
// One byte per cycle while the result is not stalled; each byte is decoded in
// a single pass of the decode logic between the input register and the result
// register. Bytes that close no output (backslash, x or 0 after it, first
// digits) give no result unless marked last. Synchronous reset clears the
// escape phase, the partial value and both valid flags.
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// C-style string unescaper with valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  esd_in_if.sink     din,
  esd_out_if.source  dout
);

  logic        in_vld;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  esd_state_t  state;
  esd_state_t  state_next;
  esd_result_t res;
  logic        out_vld;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_trunc_r;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_vld || dout.ready;
  assign advance   = in_vld && out_free;
  assign din.ready = !in_vld || advance;

  esd_decode u_decode (
    .state      (state),
    .byte_in    (in_byte_r),
    .last_in    (in_last_r),
    .state_next (state_next),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      state   <= STATE_RESET;
    end else begin
      if (din.ready) begin
        in_vld <= din.valid;
      end
      if (out_free) begin
        out_vld <= in_vld && res.emit;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_byte_r <= din.in_byte;
      in_last_r <= din.in_last;
    end
    if (advance) begin
      out_byte_r  <= res.value;
      out_last_r  <= res.last;
      out_trunc_r <= res.truncated;
    end
  end

  assign dout.valid         = out_vld;
  assign dout.out_byte      = out_byte_r;
  assign dout.out_last      = out_last_r;
  assign dout.out_truncated = out_trunc_r;

endmodule

`default_nettype wire

>>> hw/rtl/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks for the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_truncated
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_last) && $stable(out_truncated))
    else $error("result item changed while stalled");

  // truncation only marks the end of a string
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_truncated |-> out_last)
    else $error("truncated item without last mark");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .out_byte      (dout.out_byte),
  .out_last      (dout.out_last),
  .out_truncated (dout.out_truncated)
);

`default_nettype wire
